### rtl/dfcf_pkg.sv
`default_nettype none
package dfcf_pkg;

  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CFG_COL_W = 8;

  localparam logic [7:0] CH_SEPARATOR = 8'h3A;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  localparam logic [1:0] REG_FIRST_COLUMN  = 2'd0;
  localparam logic [1:0] REG_SECOND_COLUMN = 2'd1;
  localparam logic [1:0] REG_COMPARE_MODE  = 2'd2;

  localparam logic [CFG_COL_W-1:0] FIRST_COLUMN_RST  = 8'd1;
  localparam logic [CFG_COL_W-1:0] SECOND_COLUMN_RST = 8'd2;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    CMP_EQ    = 3'd0,
    CMP_GE    = 3'd1,
    CMP_LE    = 3'd2,
    CMP_GT    = 3'd3,
    CMP_LT    = 3'd4,
    CMP_NE    = 3'd5,
    CMP_NEVER = 3'd6
  } cmp_mode_t;

  typedef struct packed {
    logic [CFG_COL_W-1:0] first_column;
    logic [CFG_COL_W-1:0] second_column;
    cmp_mode_t            compare_mode;
  } cfg_t;

  typedef struct packed {
    logic step;
    logic clear;
  } parse_ctl_t;

endpackage
`default_nettype wire

### rtl/dfcf_channels.sv
`default_nettype none
interface dfcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, ch, line_end, input ready);
  modport sink (input valid, ch, line_end, output ready);
endinterface

interface dfcf_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          match;
  logic signed [VALUE_WIDTH-1:0] left_value;
  logic signed [VALUE_WIDTH-1:0] right_value;

  modport source (output valid, match, left_value, right_value, input ready);
  modport sink (input valid, match, left_value, right_value, output ready);
endinterface
`default_nettype wire

### rtl/dfcf_regs.sv
`default_nettype none
module dfcf_regs
  import dfcf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_FIRST_COLUMN:  cfg_nxt.first_column  = pwdata[CFG_COL_W-1:0];
        REG_SECOND_COLUMN: cfg_nxt.second_column = pwdata[CFG_COL_W-1:0];
        REG_COMPARE_MODE:  cfg_nxt.compare_mode  = cmp_mode_t'(pwdata[2:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FIRST_COLUMN:  prdata = {{(DATA_W-CFG_COL_W){1'b0}}, cfg_r.first_column};
      REG_SECOND_COLUMN: prdata = {{(DATA_W-CFG_COL_W){1'b0}}, cfg_r.second_column};
      REG_COMPARE_MODE:  prdata = {{(DATA_W-3){1'b0}}, cfg_r.compare_mode};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_column  <= FIRST_COLUMN_RST;
      cfg_r.second_column <= SECOND_COLUMN_RST;
      cfg_r.compare_mode  <= CMP_EQ;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/dfcf_parser.sv
`default_nettype none
module dfcf_parser
  import dfcf_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire parse_ctl_t                    ctl,
  input  wire logic [7:0]                    ch,
  output logic signed [VALUE_WIDTH-1:0]      value
);

  localparam logic [VALUE_WIDTH-1:0] MAG_CAP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] POS_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  phase_t                 phase_r, phase_nxt, phase_f;
  logic                   neg_r, neg_nxt, neg_f;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt, mag_f;
  logic [VALUE_WIDTH+3:0] acc;
  logic [VALUE_WIDTH-1:0] mag_dig;
  logic                   is_digit;
  logic                   is_space;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));

  always_comb begin
    acc = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1) + {{VALUE_WIDTH{1'b0}}, ch[3:0]};
    mag_dig = (acc > {4'b0, MAG_CAP}) ? MAG_CAP : acc[VALUE_WIDTH-1:0];
  end

  always_comb begin
    phase_f = phase_r;
    neg_f   = neg_r;
    mag_f   = mag_r;
    if (ctl.step) begin
      case (phase_r)
        PH_SKIP: begin
          if (is_space) begin
            phase_f = PH_SKIP;
          end else if (ch == CH_PLUS) begin
            phase_f = PH_DIGITS;
          end else if (ch == CH_MINUS) begin
            neg_f   = 1'b1;
            phase_f = PH_DIGITS;
          end else if (is_digit) begin
            mag_f   = mag_dig;
            phase_f = PH_DIGITS;
          end else begin
            phase_f = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            mag_f = mag_dig;
          end else begin
            phase_f = PH_DONE;
          end
        end
        default: ;
      endcase
    end
    if (ctl.clear) begin
      phase_nxt = PH_SKIP;
      neg_nxt   = 1'b0;
      mag_nxt   = '0;
    end else begin
      phase_nxt = phase_f;
      neg_nxt   = neg_f;
      mag_nxt   = mag_f;
    end
  end

  always_comb begin
    if (neg_f) begin
      value = (mag_f == '0) ? '0 : $signed({VALUE_WIDTH{1'b0}} - mag_f);
    end else if (mag_f[VALUE_WIDTH-1]) begin
      value = $signed(POS_MAX);
    end else begin
      value = $signed(mag_f);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      neg_r   <= 1'b0;
      mag_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/delimited_field_compare_filter.sv
`default_nettype none
// Filters text lines fed one character per request, the last character of a line
// marked by line_end. Columns are split at ':' and counted from 1; the configured
// first and second columns are read as signed decimal integers (leading whitespace
// skipped, one optional sign, digits up to the first non-digit; a missing or empty
// field is 0, magnitudes saturate at VALUE_WIDTH) and on each line end one result
// carries both values and the flag of the selected relation (mode 6 or 7 never
// matches). The block takes one character every clock unless a line end waits in the
// input register behind an unaccepted result; that rate is set by the combinational
// multiply-by-ten-and-add update of each field parser, which feeds its own magnitude
// register. When a line's last character leaves the input register, the line result
// is loaded into the output register. The user must write configuration over the APB
// port only while no line is in flight; the block itself does not enforce this.
module delimited_field_compare_filter
  import dfcf_pkg::*;
#(
  parameter int VALUE_WIDTH  = 32,
  parameter int COLUMN_WIDTH = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  dfcf_in_if.sink                in_chan,
  dfcf_out_if.source             out_chan,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int CMP_W = (COLUMN_WIDTH > CFG_COL_W) ? COLUMN_WIDTH : CFG_COL_W;
  localparam logic [COLUMN_WIDTH-1:0] COL_ONE = {{(COLUMN_WIDTH-1){1'b0}}, 1'b1};

  cfg_t cfg;

  logic                          s1_valid_r, s1_valid_nxt;
  logic [7:0]                    s1_ch_r;
  logic                          s1_last_r;
  logic                          s1_adv;
  logic                          s1_sep;
  logic                          load;

  logic [COLUMN_WIDTH-1:0]       col_r, col_nxt;
  parse_ctl_t                    left_ctl, right_ctl;
  logic signed [VALUE_WIDTH-1:0] left_val, right_val;
  logic                          match_c;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_match_r;
  logic signed [VALUE_WIDTH-1:0] out_left_r, out_right_r;

  dfcf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_adv = s1_valid_r && (!s1_last_r || !out_valid_r || out_chan.ready);
  assign load   = s1_adv && s1_last_r;
  assign s1_sep = (s1_ch_r == CH_SEPARATOR);

  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_comb begin
    left_ctl.step   = s1_adv && !s1_sep &&
                      (CMP_W'(col_r) == CMP_W'(cfg.first_column));
    left_ctl.clear  = load;
    right_ctl.step  = s1_adv && !s1_sep &&
                      (CMP_W'(col_r) == CMP_W'(cfg.second_column));
    right_ctl.clear = load;
  end

  dfcf_parser #(.VALUE_WIDTH(VALUE_WIDTH)) u_left (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (left_ctl),
    .ch    (s1_ch_r),
    .value (left_val)
  );

  dfcf_parser #(.VALUE_WIDTH(VALUE_WIDTH)) u_right (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (right_ctl),
    .ch    (s1_ch_r),
    .value (right_val)
  );

  always_comb begin
    col_nxt = col_r;
    if (load) begin
      col_nxt = COL_ONE;
    end else if (s1_adv && s1_sep && (col_r != '1)) begin
      col_nxt = col_r + COL_ONE;
    end
  end

  always_comb begin
    case (cfg.compare_mode)
      CMP_EQ:  match_c = (left_val == right_val);
      CMP_GE:  match_c = (left_val >= right_val);
      CMP_LE:  match_c = (left_val <= right_val);
      CMP_GT:  match_c = (left_val > right_val);
      CMP_LT:  match_c = (left_val < right_val);
      CMP_NE:  match_c = (left_val != right_val);
      default: match_c = 1'b0;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_chan.ready) begin
      s1_valid_nxt = in_chan.valid;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= COL_ONE;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_ch_r   <= in_chan.ch;
      s1_last_r <= in_chan.line_end;
    end
    if (load) begin
      out_match_r <= match_c;
      out_left_r  <= left_val;
      out_right_r <= right_val;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.match       = out_match_r;
  assign out_chan.left_value  = out_left_r;
  assign out_chan.right_value = out_right_r;

  a_out_from_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(load))
    else $error("result raised without a line end");

  a_col_restart: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (col_r == COL_ONE))
    else $error("column count not restarted after line end");

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_chan.ready)
    else $error("input stalled with free output register");

  a_never_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !(cfg.compare_mode == CMP_EQ || cfg.compare_mode == CMP_GE ||
               cfg.compare_mode == CMP_LE || cfg.compare_mode == CMP_GT ||
               cfg.compare_mode == CMP_LT || cfg.compare_mode == CMP_NE))
      |=> !out_match_r)
    else $error("match flagged under a never-matching mode");

endmodule
`default_nettype wire

### dv/delimited_field_compare_filter_tb.sv
`timescale 1ns / 100ps
module delimited_field_compare_filter_tb
  import dfcf_pkg::*;
;

  localparam int VALUE_W = 32;
  localparam int COL_W = 8;
  localparam int RANDOM_ITEMS = 120;
  localparam int RECORDS_PER_PHASE = 3;
  localparam int STALL_CYCLES = 400;
  localparam int DRAIN_CYCLES = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [2:0] CMP_UNDEFINED = 3'd7;
  localparam logic [VALUE_W-1:0] MAG_LIMIT = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] POS_LIMIT = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [COL_W-1:0] COL_LAST = '1;

  typedef logic [7:0] text_t[$];

  typedef struct {
    phase_t               phase;
    logic                 negative;
    logic [VALUE_W-1:0]   magnitude;
  } field_parse_t;

  typedef struct {
    logic                      match;
    logic signed [VALUE_W-1:0] left_value;
    logic signed [VALUE_W-1:0] right_value;
  } line_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  logic sink_hold;
  logic steady_flow;

  dfcf_in_if in_if ();
  dfcf_out_if #(.VALUE_WIDTH(VALUE_W)) out_if ();

  delimited_field_compare_filter #(
    .VALUE_WIDTH(VALUE_W),
    .COLUMN_WIDTH(COL_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if),
    .out_chan(out_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  logic [COL_W-1:0] cfg_first = FIRST_COLUMN_RST;
  logic [COL_W-1:0] cfg_second = SECOND_COLUMN_RST;
  logic [2:0]       cfg_mode = CMP_EQ;

  logic [COL_W-1:0] col_index = COL_W'(1);
  field_parse_t     left_field = '{PH_SKIP, 1'b0, '0};
  field_parse_t     right_field = '{PH_SKIP, 1'b0, '0};
  line_result_t     pending_results[$];

  int errors = 0;
  int chars_sent = 0;
  int lines_checked = 0;
  int matches_seen = 0;
  int stall_count = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic field_parse_t advance_field(input field_parse_t f, input logic [7:0] c);
    logic is_digit;
    logic is_space;
    logic [VALUE_W-1:0] d;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    d = VALUE_W'(c - CH_ZERO);
    if (f.phase == PH_SKIP && !is_digit) begin
      if (c == CH_PLUS) begin
        f.phase = PH_DIGITS;
      end else if (c == CH_MINUS) begin
        f.negative = 1'b1;
        f.phase = PH_DIGITS;
      end else if (!is_space) begin
        f.phase = PH_DONE;
      end
    end else if (f.phase == PH_SKIP || f.phase == PH_DIGITS) begin
      if (!is_digit) begin
        f.phase = PH_DONE;
      end else begin
        if (f.magnitude > (MAG_LIMIT - d) / 10) f.magnitude = MAG_LIMIT;
        else f.magnitude = f.magnitude * 10 + d;
        f.phase = PH_DIGITS;
      end
    end
    return f;
  endfunction

  function automatic logic signed [VALUE_W-1:0] field_value(input field_parse_t f);
    if (f.negative) return -f.magnitude;
    if (f.magnitude >= MAG_LIMIT) return POS_LIMIT;
    return f.magnitude;
  endfunction

  function automatic void consume_char(input logic [7:0] c, input logic last);
    line_result_t res;
    if (c == CH_SEPARATOR) begin
      if (col_index != COL_LAST) col_index++;
    end else begin
      if (col_index == cfg_first) left_field = advance_field(left_field, c);
      if (col_index == cfg_second) right_field = advance_field(right_field, c);
    end
    if (last) begin
      res.left_value = field_value(left_field);
      res.right_value = field_value(right_field);
      case (cfg_mode)
        CMP_EQ: res.match = res.left_value == res.right_value;
        CMP_GE: res.match = res.left_value >= res.right_value;
        CMP_LE: res.match = res.left_value <= res.right_value;
        CMP_GT: res.match = res.left_value > res.right_value;
        CMP_LT: res.match = res.left_value < res.right_value;
        CMP_NE: res.match = res.left_value != res.right_value;
        default: res.match = 1'b0;
      endcase
      pending_results.push_back(res);
      col_index = COL_W'(1);
      left_field = '{PH_SKIP, 1'b0, '0};
      right_field = '{PH_SKIP, 1'b0, '0};
    end
  endfunction

  task automatic check_result();
    line_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with no line pending: match %0b left %0d right %0d",
                                out_if.match, out_if.left_value, out_if.right_value));
      return;
    end
    want = pending_results.pop_front();
    lines_checked++;
    if (out_if.match === 1'b1) matches_seen++;
    if (out_if.match !== want.match)
      report_mismatch($sformatf("line %0d match %b, want %b", lines_checked,
                                out_if.match, want.match));
    if (out_if.left_value !== want.left_value)
      report_mismatch($sformatf("line %0d left_value %0d, want %0d", lines_checked,
                                out_if.left_value, want.left_value));
    if (out_if.right_value !== want.right_value)
      report_mismatch($sformatf("line %0d right_value %0d, want %0d", lines_checked,
                                out_if.right_value, want.right_value));
  endtask

  always @(posedge clk) begin
    if (in_if.valid === 1'b1 && in_if.ready === 1'b1) consume_char(in_if.ch, in_if.line_end);
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_result();
  end

  always @(posedge clk) begin
    if (sink_hold) out_if.ready <= 1'b0;
    else if (steady_flow) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
      stall_count = 0;
    else
      stall_count++;
    if (stall_count >= WATCHDOG_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("delimited_field_compare_filter_tb NOT OK");
      $finish;
    end
  end

  task automatic send_request(input logic [7:0] c, input logic last);
    while (!steady_flow && $urandom_range(99) < 16) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch <= c;
    in_if.line_end <= last;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    chars_sent++;
  endtask

  task automatic send_text(input text_t text);
    for (int i = 0; i < text.size(); i++) send_request(text[i], i == text.size() - 1);
  endtask

  task automatic send_line(input string s);
    text_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text(text);
  endtask

  task automatic drain_lines();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] register_value(input logic [1:0] index);
    case (index)
      REG_FIRST_COLUMN:  return DATA_W'(cfg_first);
      REG_SECOND_COLUMN: return DATA_W'(cfg_second);
      REG_COMPARE_MODE:  return DATA_W'(cfg_mode);
      default:           return '0;
    endcase
  endfunction

  task automatic write_register(input logic [1:0] index, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({index, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (index)
      REG_FIRST_COLUMN:  cfg_first = value[COL_W-1:0];
      REG_SECOND_COLUMN: cfg_second = value[COL_W-1:0];
      REG_COMPARE_MODE:  cfg_mode = value[2:0];
      default: ;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== register_value(index))
      report_mismatch($sformatf("register %0d reads %0h, want %0h", index, readback,
                                register_value(index)));
  endtask

  task automatic configure(input logic [COL_W-1:0] first, input logic [COL_W-1:0] second,
                           input logic [2:0] mode);
    write_register(REG_FIRST_COLUMN, {8'($urandom_range(255)), 16'h0, first});
    write_register(REG_SECOND_COLUMN, {8'($urandom_range(255)), 16'h0, second});
    write_register(REG_COMPARE_MODE, {24'h0, 5'($urandom_range(31)), mode});
  endtask

  function automatic logic [7:0] pick_space();
    if ($urandom_range(5) == 0) return CH_SPACE;
    return CH_TAB + 8'($urandom_range(4));
  endfunction

  function automatic logic [COL_W-1:0] pick_column();
    case ($urandom_range(9))
      0: return '0;
      1: return COL_LAST;
      default: return COL_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic void append_field(ref text_t text);
    int unsigned digits;
    int unsigned spaces;
    spaces = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (spaces) text.push_back(pick_space());
    case ($urandom_range(5))
      0: text.push_back(CH_PLUS);
      1: text.push_back(CH_MINUS);
      default: ;
    endcase
    digits = ($urandom_range(11) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
    repeat (digits) text.push_back(CH_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(4) == 0) text.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void build_record(ref text_t text);
    int unsigned fields;
    text.delete();
    if ($urandom_range(9) < 2) begin
      repeat ($urandom_range(1, 10))
        text.push_back(($urandom_range(3) == 0) ? CH_SEPARATOR : 8'($urandom_range(255)));
    end else begin
      fields = $urandom_range(1, 5);
      for (int i = 0; i < fields; i++) begin
        if (i != 0) text.push_back(CH_SEPARATOR);
        append_field(text);
      end
    end
    if (text.size() == 0) text.push_back(pick_space());
  endfunction

  task automatic test_parse_rules();
    text_t odd_bytes;
    odd_bytes = '{8'h00, "9", CH_SEPARATOR, "3", 8'hFF, "4"};
    send_line(" \t\n+42:\013\014\015-42");
    send_line("-:+");
    send_line(":");
    send_line("7");
    send_line("12x3:12");
    send_line("- 5: 5");
    send_line("2147483647:-2147483648");
    send_line("2147483648:-2147483649");
    send_line("99999999999:-99999999999");
    send_text(odd_bytes);
    drain_lines();
  endtask

  task automatic test_register_access();
    configure(COL_LAST, COL_LAST, CMP_UNDEFINED);
    configure(8'h0, 8'h0, CMP_NEVER);
    configure(FIRST_COLUMN_RST, SECOND_COLUMN_RST, CMP_EQ);
    drain_lines();
  endtask

  task automatic test_compare_modes();
    for (int m = 0; m < 8; m++) begin
      configure(FIRST_COLUMN_RST, SECOND_COLUMN_RST, 3'(m));
      send_line("4:4");
      send_line("-8:3");
      send_line("3:-8");
      drain_lines();
    end
  endtask

  task automatic test_column_selection();
    configure(8'd2, 8'd2, CMP_EQ);
    send_line("1:-33x:5");
    drain_lines();
    configure(8'd0, COL_LAST, CMP_LE);
    send_line("5:6");
    drain_lines();
    configure(8'd4, 8'd0, CMP_GE);
    send_line("1:2");
    drain_lines();
    configure(8'd3, 8'd1, CMP_GT);
    send_line("1:2:+77");
    drain_lines();
  endtask

  task automatic test_separator_saturation();
    text_t text;
    configure(COL_LAST, FIRST_COLUMN_RST, CMP_NE);
    text.push_back("5");
    repeat (260) text.push_back(CH_SEPARATOR);
    text.push_back("5");
    text.push_back(CH_SEPARATOR);
    text.push_back("0");
    send_text(text);
    drain_lines();
  endtask

  task automatic test_output_stall();
    text_t text;
    configure(FIRST_COLUMN_RST, SECOND_COLUMN_RST, CMP_LT);
    fork
      begin
        sink_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
      end
    join_none
    repeat (4) begin
      build_record(text);
      send_text(text);
    end
    drain_lines();
  endtask

  task automatic test_random_records();
    text_t text;
    int sent;
    int phase_index;
    sent = 0;
    phase_index = 0;
    while (sent < RANDOM_ITEMS || phase_index < 3) begin
      steady_flow <= (phase_index == 2);
      configure(pick_column(), pick_column(), 3'($urandom_range(7)));
      repeat (RECORDS_PER_PHASE) begin
        build_record(text);
        send_text(text);
        sent += text.size();
      end
      drain_lines();
      phase_index++;
    end
    steady_flow <= 1'b0;
    drain_lines();
  endtask

  initial begin
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.ch <= '0;
    in_if.line_end <= 1'b0;
    sink_hold <= 1'b0;
    steady_flow <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_parse_rules();
    test_register_access();
    test_compare_modes();
    test_column_selection();
    test_separator_saturation();
    test_output_stall();
    test_random_records();

    $display("checked %0d lines (%0d matching) from %0d characters", lines_checked,
             matches_seen, chars_sent);
    $display("covered all compare modes, column 0 and 255, saturation and output stall");
    if (errors == 0) begin
      $display("delimited_field_compare_filter_tb OK");
    end else begin
      $display("delimited_field_compare_filter_tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dfcf_pkg.sv
rtl/dfcf_channels.sv
rtl/dfcf_regs.sv
rtl/dfcf_parser.sv
rtl/delimited_field_compare_filter.sv
dv/delimited_field_compare_filter_tb.sv
